// File: design/lag_pkg.sv
package lag_pkg;

  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 4;
  localparam int COORD_W = 6;
  localparam int DIM_MIN = 3;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 4'd1;

  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CELL    = 7'b0000010,
    S_GEN_PRE = 7'b0000100,
    S_GEN_ROW = 7'b0001000,
    S_SWP_RD  = 7'b0010000,
    S_SWP_WR  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic clr_all;
  } mem_ctl_t;

  function automatic logic [3:0] count8(input logic [7:0] v);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, v[i]};
    end
    return sum;
  endfunction

  function automatic logic life_next(input logic alive, input logic [3:0] n);
    logic res;
    if (alive) begin
      res = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
    end else begin
      res = (n == BIRTH_COUNT);
    end
    return res;
  endfunction

endpackage

// File: design/lag_row_update.sv
module lag_row_update #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]             above,
  input  logic [WIDTH-1:0]             cur,
  input  logic [WIDTH-1:0]             below,
  input  logic [$clog2(WIDTH+1)-1:0]   act_w,
  output logic [WIDTH-1:0]             new_row
);

  localparam int CW = $clog2(WIDTH);
  localparam int WDW = $clog2(WIDTH + 1);

  logic [WDW-1:0] wm1_full;
  logic [CW-1:0]  wm1;
  logic [WIDTH-1:0] a_l, a_r, c_l, c_r, b_l, b_r;

  assign wm1_full = act_w - 1'b1;
  assign wm1 = wm1_full[CW-1:0];

  // wrapped left and right neighbor vectors
  always_comb begin
    for (int x = 0; x < WIDTH; x++) begin
      if (x == 0) begin
        a_l[x] = above[wm1];
        c_l[x] = cur[wm1];
        b_l[x] = below[wm1];
      end else begin
        a_l[x] = above[x-1];
        c_l[x] = cur[x-1];
        b_l[x] = below[x-1];
      end
      if (CW'(x) == wm1) begin
        a_r[x] = above[0];
        c_r[x] = cur[0];
        b_r[x] = below[0];
      end else if (x == WIDTH - 1) begin
        a_r[x] = 1'b0;
        c_r[x] = 1'b0;
        b_r[x] = 1'b0;
      end else begin
        a_r[x] = above[x+1];
        c_r[x] = cur[x+1];
        b_r[x] = below[x+1];
      end
    end
  end

  always_comb begin
    for (int x = 0; x < WIDTH; x++) begin
      if (WDW'(x) < act_w) begin
        new_row[x] = lag_pkg::life_next(cur[x], lag_pkg::count8(
          {a_l[x], above[x], a_r[x], c_l[x], c_r[x], b_l[x], below[x], b_r[x]}));
      end else begin
        new_row[x] = 1'b0;
      end
    end
  end

endmodule

// File: design/lag_cell_mem.sv
module lag_cell_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lag_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [WIDTH-1:0] q_a, q_b;
  logic             v_a, v_b;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
  end

  // a row never written since reset or clear reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      v_a <= row_valid[rd_addr_a];
      v_b <= row_valid[rd_addr_b];
    end
  end

  assign rd_data_a = v_a ? q_a : '0;
  assign rd_data_b = v_b ? q_b : '0;

endmodule

// File: design/life_automaton_toroidal_grid_top.sv
// Toroidal B3/S23 cell grid of up to MAX_WIDTH by MAX_HEIGHT cells.
// Item channel: item_valid / item_stall with operation, col_x, row_y, alive_in.
// Result channel: result_valid / result_stall with cell_value and status,
// exactly one result word per item word.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// sets grid_width, index 1 grid_height, other indexes are ignored.
// From item accept to result valid: an in-range read or write does a row read,
// then a row write; clear or an out-of-range access goes straight to the result;
// a generation loads the first and last rows, then updates each active row in
// turn. The row update unit handles one whole row per cycle, so a generation
// holds the item channel until it is done; the sequencer returns to idle as the
// result is registered, and a pending config write goes before the next item.
// A config write to index 0 or 1 starts a sweep over every row of the cell memory
// that clears cells outside the new active area; items stall meanwhile.
// The output register lets the next item be accepted while a result waits;
// a stalled result holds, and a following result waits in the sequencer.
// Reset (rst, synchronous) empties the grid, sets both sizes to 64 and drops
// any pending result.
module life_automaton_toroidal_grid_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      operation,
  input  logic [lag_pkg::COORD_W-1:0]     col_x,
  input  logic [lag_pkg::COORD_W-1:0]     row_y,
  input  logic                            alive_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            cell_value,
  output logic                            status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lag_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W = (WDW > lag_pkg::CFG_W) ? WDW : lag_pkg::CFG_W;
  localparam int CMP_H = (HDW > lag_pkg::CFG_W) ? HDW : lag_pkg::CFG_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);

  lag_pkg::state_t state;

  logic [lag_pkg::CFG_W-1:0] grid_width, grid_height;

  logic [CMP_W-1:0] gw_ext, act_w_full, x_ext;
  logic [CMP_H-1:0] gh_ext, act_h_full, y_ext;
  logic [WDW-1:0]   act_w;
  logic [HDW-1:0]   act_h;
  logic [HDW-1:0]   hm1_full;
  logic [RW-1:0]    hm1;
  logic [CW-1:0]    x_idx;
  logic [RW-1:0]    y_idx;
  logic             out_of_area;

  logic [CW-1:0] cell_x;
  logic [RW-1:0] cell_y;
  logic          cell_alive;
  logic          cell_is_write;

  logic [RW-1:0]        cnt;
  logic [MAX_WIDTH-1:0] above_row, cur_row, first_row, below_row, new_row;
  logic [MAX_WIDTH-1:0] col_mask, cell_row_mod;

  logic                 res_value, res_status;

  lag_pkg::mem_ctl_t    mem_ctl;
  logic [RW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic [MAX_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;

  logic item_accept, cfg_accept, out_free, cfg_known;

  // effective sizes, clamped to the supported range
  assign gw_ext = CMP_W'(grid_width);
  assign gh_ext = CMP_H'(grid_height);
  assign act_w_full = (gw_ext < CMP_W'(lag_pkg::DIM_MIN)) ? CMP_W'(lag_pkg::DIM_MIN) :
                      (gw_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : gw_ext;
  assign act_h_full = (gh_ext < CMP_H'(lag_pkg::DIM_MIN)) ? CMP_H'(lag_pkg::DIM_MIN) :
                      (gh_ext > CMP_H'(MAX_HEIGHT)) ? CMP_H'(MAX_HEIGHT) : gh_ext;
  assign act_w = act_w_full[WDW-1:0];
  assign act_h = act_h_full[HDW-1:0];
  assign hm1_full = act_h - 1'b1;
  assign hm1 = hm1_full[RW-1:0];

  assign x_ext = CMP_W'(col_x);
  assign y_ext = CMP_H'(row_y);
  assign x_idx = x_ext[CW-1:0];
  assign y_idx = y_ext[RW-1:0];
  assign out_of_area = (x_ext >= act_w_full) || (y_ext >= act_h_full);

  always_comb begin
    for (int x = 0; x < MAX_WIDTH; x++) begin
      col_mask[x] = (WDW'(x) < act_w);
    end
  end

  assign item_stall = (state != lag_pkg::S_IDLE) || cfg_valid;
  assign cfg_ready = (state == lag_pkg::S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == lag_pkg::CFG_GRID_WIDTH) ||
                     (cfg_index == lag_pkg::CFG_GRID_HEIGHT);
  assign out_free = !result_valid || !result_stall;

  assign below_row = (cnt == hm1) ? first_row : rd_data_a;

  always_comb begin
    cell_row_mod = rd_data_a;
    cell_row_mod[cell_x] = cell_alive;
  end

  lag_row_update #(
    .WIDTH(MAX_WIDTH)
  ) u_row_update (
    .above  (above_row),
    .cur    (cur_row),
    .below  (below_row),
    .act_w  (act_w),
    .new_row(new_row)
  );

  // memory port selection
  always_comb begin
    mem_ctl.wr_en = 1'b0;
    mem_ctl.clr_all = 1'b0;
    wr_addr = cnt;
    wr_data = new_row;
    rd_addr_b = hm1;
    case (state)
      lag_pkg::S_IDLE: begin
        rd_addr_a = (operation == lag_pkg::OP_ADVANCE) ? '0 : y_idx;
        mem_ctl.clr_all = item_accept && (operation == lag_pkg::OP_CLEAR);
      end
      lag_pkg::S_CELL: begin
        rd_addr_a = cnt;
        mem_ctl.wr_en = cell_is_write;
        wr_addr = cell_y;
        wr_data = cell_row_mod;
      end
      lag_pkg::S_GEN_PRE: begin
        rd_addr_a = RW'(1);
      end
      lag_pkg::S_GEN_ROW: begin
        rd_addr_a = cnt + RW'(2);
        mem_ctl.wr_en = 1'b1;
      end
      lag_pkg::S_SWP_WR: begin
        rd_addr_a = cnt;
        mem_ctl.wr_en = 1'b1;
        wr_data = (HDW'(cnt) < act_h) ? (rd_data_a & col_mask) : '0;
      end
      default: begin
        rd_addr_a = cnt;
      end
    endcase
  end

  lag_cell_mem #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_cell_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lag_pkg::S_IDLE;
      grid_width <= lag_pkg::GRID_DIM_RESET;
      grid_height <= lag_pkg::GRID_DIM_RESET;
      cnt <= '0;
    end else begin
      case (state)
        lag_pkg::S_IDLE: begin
          if (cfg_accept) begin
            if (cfg_index == lag_pkg::CFG_GRID_WIDTH) begin
              grid_width <= cfg_data;
            end else if (cfg_index == lag_pkg::CFG_GRID_HEIGHT) begin
              grid_height <= cfg_data;
            end
            if (cfg_known) begin
              cnt <= '0;
              state <= lag_pkg::S_SWP_RD;
            end
          end else if (item_accept) begin
            case (operation)
              lag_pkg::OP_WRITE, lag_pkg::OP_READ: begin
                state <= out_of_area ? lag_pkg::S_DONE : lag_pkg::S_CELL;
              end
              lag_pkg::OP_ADVANCE: begin
                state <= lag_pkg::S_GEN_PRE;
              end
              default: begin
                state <= lag_pkg::S_DONE;
              end
            endcase
          end
        end
        lag_pkg::S_CELL: begin
          state <= lag_pkg::S_DONE;
        end
        lag_pkg::S_GEN_PRE: begin
          cnt <= '0;
          state <= lag_pkg::S_GEN_ROW;
        end
        lag_pkg::S_GEN_ROW: begin
          if (cnt == hm1) begin
            state <= lag_pkg::S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        lag_pkg::S_SWP_RD: begin
          state <= lag_pkg::S_SWP_WR;
        end
        lag_pkg::S_SWP_WR: begin
          if (cnt == LAST_ROW) begin
            state <= lag_pkg::S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= lag_pkg::S_SWP_RD;
          end
        end
        lag_pkg::S_DONE: begin
          if (out_free) begin
            state <= lag_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lag_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      lag_pkg::S_IDLE: begin
        cell_x <= x_idx;
        cell_y <= y_idx;
        cell_alive <= alive_in;
        cell_is_write <= (operation == lag_pkg::OP_WRITE);
        res_value <= 1'b0;
        res_status <= ((operation == lag_pkg::OP_WRITE) ||
                       (operation == lag_pkg::OP_READ)) && out_of_area;
      end
      lag_pkg::S_CELL: begin
        res_value <= cell_is_write ? cell_alive : rd_data_a[cell_x];
      end
      lag_pkg::S_GEN_PRE: begin
        cur_row <= rd_data_a;
        first_row <= rd_data_a;
        above_row <= rd_data_b;
      end
      lag_pkg::S_GEN_ROW: begin
        above_row <= cur_row;
        cur_row <= below_row;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == lag_pkg::S_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lag_pkg::S_DONE) && out_free) begin
      cell_value <= res_value;
      status <= res_status;
    end
  end

endmodule

// File: dv/tb_life_automaton_toroidal_grid_top.sv
module tb_life_automaton_toroidal_grid_top;

  localparam int GRID_MAX = 64;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLDOFF_CYCLES = 400;
  localparam logic [lag_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 4'd5;
  localparam logic [lag_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = 4'd15;

  typedef struct packed {
    logic cell_bit;
    logic stat_bit;
  } grid_reply_t;

  typedef struct {
    bit is_cfg;
    logic [lag_pkg::CFG_IDX_W-1:0] idx;
    logic [lag_pkg::CFG_W-1:0] data;
    lag_pkg::op_t op;
    logic [lag_pkg::COORD_W-1:0] x;
    logic [lag_pkg::COORD_W-1:0] y;
    logic a;
    bit typed;
    grid_reply_t reply;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] operation = lag_pkg::OP_READ;
  logic [lag_pkg::COORD_W-1:0] col_x = '0;
  logic [lag_pkg::COORD_W-1:0] row_y = '0;
  logic alive_in = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic cell_value;
  logic status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lag_pkg::CFG_W-1:0] cfg_data = '0;

  logic holding = 1'b0;
  bit pressure_on = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;

  // predicted grid state
  logic [GRID_MAX-1:0] life_cells [GRID_MAX];
  logic [lag_pkg::CFG_W-1:0] width_reg = lag_pkg::GRID_DIM_RESET;
  logic [lag_pkg::CFG_W-1:0] height_reg = lag_pkg::GRID_DIM_RESET;
  grid_reply_t pending_replies [$];
  stim_row_t stim_rows [$];

  life_automaton_toroidal_grid_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .col_x(col_x),
    .row_y(row_y),
    .alive_in(alive_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cell_value(cell_value),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_dim(logic [lag_pkg::CFG_W-1:0] v);
    if (v < lag_pkg::DIM_MIN) return lag_pkg::DIM_MIN;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  task automatic size_write(input logic [lag_pkg::CFG_IDX_W-1:0] idx,
                            input logic [lag_pkg::CFG_W-1:0] data);
    int w;
    int h;
    if (idx == lag_pkg::CFG_GRID_WIDTH) begin
      width_reg = data;
    end else if (idx == lag_pkg::CFG_GRID_HEIGHT) begin
      height_reg = data;
    end else begin
      return;
    end
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    for (int y = 0; y < GRID_MAX; y++) begin
      for (int x = 0; x < GRID_MAX; x++) begin
        if (y >= h || x >= w) life_cells[y][x] = 1'b0;
      end
    end
  endtask

  task automatic life_generation();
    logic [GRID_MAX-1:0] old_cells [GRID_MAX];
    int w;
    int h;
    int n;
    int xl;
    int xr;
    int yu;
    int yd;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    for (int y = 0; y < GRID_MAX; y++) old_cells[y] = life_cells[y];
    for (int y = 0; y < h; y++) begin
      yu = (y == 0) ? h - 1 : y - 1;
      yd = (y + 1 == h) ? 0 : y + 1;
      for (int x = 0; x < w; x++) begin
        xl = (x == 0) ? w - 1 : x - 1;
        xr = (x + 1 == w) ? 0 : x + 1;
        n = old_cells[yu][xl] + old_cells[yu][x] + old_cells[yu][xr]
          + old_cells[y][xl] + old_cells[y][xr]
          + old_cells[yd][xl] + old_cells[yd][x] + old_cells[yd][xr];
        if (old_cells[y][x]) life_cells[y][x] = (n == 2 || n == 3);
        else life_cells[y][x] = (n == 3);
      end
    end
  endtask

  task automatic life_predict_reply(input lag_pkg::op_t op,
                                    input logic [lag_pkg::COORD_W-1:0] x,
                                    input logic [lag_pkg::COORD_W-1:0] y, input logic a,
                                    output grid_reply_t r);
    r = '0;
    case (op)
      lag_pkg::OP_WRITE, lag_pkg::OP_READ: begin
        if (x >= eff_dim(width_reg) || y >= eff_dim(height_reg)) begin
          r.stat_bit = 1'b1;
        end else begin
          if (op == lag_pkg::OP_WRITE) life_cells[y][x] = a;
          r.cell_bit = life_cells[y][x];
        end
      end
      lag_pkg::OP_ADVANCE: begin
        life_generation();
      end
      default: begin
        for (int i = 0; i < GRID_MAX; i++) life_cells[i] = '0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic drive_item(input lag_pkg::op_t op, input logic [lag_pkg::COORD_W-1:0] x,
                            input logic [lag_pkg::COORD_W-1:0] y, input logic a,
                            input bit typed, input grid_reply_t typed_reply);
    grid_reply_t pred;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    col_x <= x;
    row_y <= y;
    alive_in <= a;
    do @(posedge clk); while (item_stall);
    life_predict_reply(op, x, y, a, pred);
    if (typed) pred = typed_reply;
    pending_replies = {pending_replies, pred};
  endtask

  task automatic write_size_reg(input logic [lag_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lag_pkg::CFG_W-1:0] data);
    item_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_write(idx, data);
  endtask

  task automatic add_item(input lag_pkg::op_t op, input int x, input int y, input logic a,
                          input bit typed, input logic c, input logic s);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, op: op,
            x: lag_pkg::COORD_W'(x), y: lag_pkg::COORD_W'(y), a: a,
            typed: typed, reply: '{cell_bit: c, stat_bit: s}};
    stim_rows = {stim_rows, row};
  endtask

  task automatic add_cfg(input logic [lag_pkg::CFG_IDX_W-1:0] idx,
                         input logic [lag_pkg::CFG_W-1:0] data);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, op: lag_pkg::OP_READ, x: '0, y: '0,
            a: 1'b0, typed: 1'b0, reply: '0};
    stim_rows = {stim_rows, row};
  endtask

  function automatic logic [lag_pkg::CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 15) return lag_pkg::CFG_W'($urandom_range(127));
    if (r < 25) return lag_pkg::CFG_W'(GRID_MAX);
    if (r < 35) return lag_pkg::CFG_W'(lag_pkg::DIM_MIN);
    return lag_pkg::CFG_W'($urandom_range(16, lag_pkg::DIM_MIN));
  endfunction

  // result checker and receiver stalls
  initial begin
    grid_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result word", cell_value, 1'b0);
        end else begin
          want = pending_replies.pop_front();
          if (cell_value !== want.cell_bit) begin
            report_mismatch("cell_value", cell_value, want.cell_bit);
          end
          if (status !== want.stat_bit) report_mismatch("status", status, want.stat_bit);
        end
      end
      result_stall <= holding || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into the item channel
  initial begin
    wait (pressure_on);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    int idle_by_phase [5];
    int stall_by_phase [5];
    lag_pkg::op_t op;
    int r;
    int aw;
    int ah;
    logic [lag_pkg::COORD_W-1:0] x;
    logic [lag_pkg::COORD_W-1:0] y;
    stim_row_t row;

    idle_by_phase = '{0, 67, 0, 16, 0};
    stall_by_phase = '{0, 0, 67, 16, 0};
    for (int i = 0; i < GRID_MAX; i++) life_cells[i] = '0;

    add_item(lag_pkg::OP_READ, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 63, 63, 1'b1, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 63, 63, 1'b1, 1'b1, 1'b1, 1'b0);
    add_item(lag_pkg::OP_WRITE, 0, 0, 1'b1, 1'b1, 1'b1, 1'b0);
    add_item(lag_pkg::OP_WRITE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    // blinker across the horizontal wrap
    add_item(lag_pkg::OP_WRITE, 63, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 1, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_ADVANCE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 0, 63, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 0, 1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 63, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_CLEAR, 5, 9, 1'b1, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 0, 1, 1'b0, 1'b1, 1'b0, 1'b0);
    // smallest grid, accesses outside it
    add_cfg(lag_pkg::CFG_GRID_WIDTH, 7'd3);
    add_cfg(lag_pkg::CFG_GRID_HEIGHT, 7'd3);
    add_item(lag_pkg::OP_WRITE, 3, 0, 1'b1, 1'b1, 1'b0, 1'b1);
    add_item(lag_pkg::OP_READ, 0, 63, 1'b0, 1'b1, 1'b0, 1'b1);
    add_item(lag_pkg::OP_WRITE, 2, 2, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 1, 1, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_ADVANCE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    // sizes below range clamp, unknown index ignored
    add_cfg(lag_pkg::CFG_GRID_WIDTH, 7'd0);
    add_cfg(lag_pkg::CFG_GRID_HEIGHT, 7'd2);
    add_cfg(CFG_NO_REG, 7'd127);
    add_item(lag_pkg::OP_READ, 2, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    // width above range clamps, height at its maximum
    add_cfg(lag_pkg::CFG_GRID_WIDTH, 7'd127);
    add_cfg(lag_pkg::CFG_GRID_HEIGHT, 7'd64);
    add_item(lag_pkg::OP_READ, 63, 63, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(lag_pkg::OP_WRITE, 42, 21, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(lag_pkg::OP_READ, 21, 42, 1'b0, 1'b0, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) write_size_reg(row.idx, row.data);
      else drive_item(row.op, row.x, row.y, row.a, row.typed, row.reply);
    end

    for (int p = 0; p < 5; p++) begin
      write_size_reg(lag_pkg::CFG_GRID_WIDTH, pick_dim());
      write_size_reg(lag_pkg::CFG_GRID_HEIGHT, pick_dim());
      if ($urandom_range(1)) begin
        write_size_reg(lag_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_LAST,
                                                          lag_pkg::CFG_GRID_HEIGHT + 1)),
                       lag_pkg::CFG_W'($urandom_range(127)));
      end
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 4) pressure_on = 1'b1;
      aw = eff_dim(width_reg);
      ah = eff_dim(height_reg);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        op = (r < 38) ? lag_pkg::OP_WRITE : (r < 76) ? lag_pkg::OP_READ :
             (r < 95) ? lag_pkg::OP_ADVANCE : lag_pkg::OP_CLEAR;
        if ($urandom_range(99) < 85) begin
          x = lag_pkg::COORD_W'($urandom_range(aw - 1));
          y = lag_pkg::COORD_W'($urandom_range(ah - 1));
        end else begin
          x = lag_pkg::COORD_W'($urandom_range(63));
          y = lag_pkg::COORD_W'($urandom_range(63));
        end
        drive_item(op, x, y, ($urandom_range(99) < 55), 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (GRID_MAX + 8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
